// ===== src/ibh_pkg.sv =====
// shared constants and types for the indexed binary heap
package ibh_pkg;
	localparam int CAPACITY = 256;
	localparam int KEY_W = 32;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = IDX_W + 1;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_DEC = 2'd1;
	localparam logic [1:0] ACT_INC = 2'd2;
	localparam logic [1:0] ACT_QUERY = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;
endpackage

// ===== src/ibh_ram.sv =====
// generic single write port ram with registered read
module ibh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/indexed_binary_heap.sv =====
// indexed binary heap top level: sequencer, shared compare and key rams
//
// Usage: items enter on in_valid/in_ready carrying action, element and value.
// One result beat leaves on out_valid/out_ready per item. in_ready is high
// only while the sequencer is idle; one item is worked at a time.
// A rejected item (heap full, element not present) goes straight to the
// result; a query reads the position and then the key. An insert, or an
// update after its position and key reads, is followed by the sift: each
// level going up is a parent read, then compare and move; each level going
// down is two child reads on the single read port of each ram, then the
// compare; a last check ends the sift. The key and id rams have a single
// read port each, and there is one shared comparator.
// max_mode is written through cfg_we/cfg_wdata; the user must do so only
// while idle (the block does not enforce it); held entries are not reordered.
// Reset empties the heap and selects min mode; the rams are not cleared,
// entries are only read below the fill count. A stalled receiver holds the
// result in the output register; the next item may be accepted meanwhile,
// and its result waits until the output register is free.
module indexed_binary_heap (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] action,
	input ibh_pkg::idx_t element,
	input ibh_pkg::key_t value,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] status,
	output ibh_pkg::idx_t new_element,
	output ibh_pkg::key_t key_out,
	output ibh_pkg::key_t top_key,
	output ibh_pkg::idx_t top_element,
	output logic is_empty,
	output ibh_pkg::cnt_t entry_count
);
	import ibh_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_POS_RD = 4'd1;
	localparam logic [3:0] S_KEY_RD = 4'd2;
	localparam logic [3:0] S_KEY_WAIT = 4'd3;
	localparam logic [3:0] S_UP_CHK = 4'd4;
	localparam logic [3:0] S_UP_CMP = 4'd5;
	localparam logic [3:0] S_DN_CHK = 4'd6;
	localparam logic [3:0] S_DN_RD2 = 4'd7;
	localparam logic [3:0] S_DN_CMP2 = 4'd8;
	localparam logic [3:0] S_DN_CMP = 4'd9;
	localparam logic [3:0] S_FIN = 4'd10;
	localparam logic [3:0] S_DONE = 4'd11;

	localparam logic signed [KEY_W+1:0] SUM_MAX = {3'b000, {(KEY_W-1){1'b1}}};
	localparam logic signed [KEY_W+1:0] SUM_MIN = {3'b111, {(KEY_W-1){1'b0}}};

	logic [3:0] state_q;
	logic max_mode_q;
	cnt_t fill_q;
	logic [1:0] act_q;
	idx_t elem_q;
	key_t val_q;
	key_t k_q;
	idx_t d_q;
	idx_t v_q;
	idx_t p_q;
	idx_t c_q;
	key_t kc_q;
	idx_t idc_q;
	logic [1:0] st_q;
	idx_t newel_q;
	key_t top_key_q;
	idx_t top_id_q;

	logic out_valid_q;
	logic [1:0] status_q;
	idx_t new_element_q;
	key_t key_out_q;
	key_t top_key_o_q;
	idx_t top_el_o_q;
	logic is_empty_q;
	cnt_t entry_count_q;

	logic key_we, pos_we;
	idx_t key_waddr, pos_waddr, kr_addr;
	key_t key_wdata, key_rdata;
	idx_t id_wdata, id_rdata, pos_wdata, pos_rdata;

	key_t cmp_a, cmp_b;
	logic better;
	logic signed [KEY_W+1:0] opnd, sum;
	key_t sat_key;
	logic [IDX_W+1:0] c_full;
	cnt_t c_next;
	logic out_load;

	ibh_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_keys (
		.clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
		.raddr(kr_addr), .rdata(key_rdata)
	);
	ibh_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_ids (
		.clk(clk), .we(key_we), .waddr(key_waddr), .wdata(id_wdata),
		.raddr(kr_addr), .rdata(id_rdata)
	);
	ibh_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_pos (
		.clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
		.raddr(elem_q), .rdata(pos_rdata)
	);

	// shared comparator: a is strictly better than b in the current mode
	always_comb begin
		case (state_q)
			S_UP_CMP: begin
				cmp_a = key_rdata;
				cmp_b = k_q;
			end
			S_DN_CMP2: begin
				cmp_a = key_rdata;
				cmp_b = kc_q;
			end
			default: begin
				cmp_a = k_q;
				cmp_b = kc_q;
			end
		endcase
		better = max_mode_q ? (cmp_a > cmp_b) : (cmp_a < cmp_b);
	end

	// saturating key update
	always_comb begin
		opnd = (act_q == ACT_DEC) ? -{{2{val_q[KEY_W-1]}}, val_q}
			: {{2{val_q[KEY_W-1]}}, val_q};
		sum = {{2{key_rdata[KEY_W-1]}}, key_rdata} + opnd;
		if (sum > SUM_MAX) begin
			sat_key = SUM_MAX[KEY_W-1:0];
		end else if (sum < SUM_MIN) begin
			sat_key = SUM_MIN[KEY_W-1:0];
		end else begin
			sat_key = sum[KEY_W-1:0];
		end
	end

	assign c_full = {1'b0, v_q, 1'b1};
	assign c_next = {1'b0, c_q} + cnt_t'(1);

	// ram read address and write port
	always_comb begin
		kr_addr = p_q;
		key_we = 1'b0;
		pos_we = 1'b0;
		key_waddr = v_q;
		key_wdata = k_q;
		id_wdata = d_q;
		pos_waddr = d_q;
		pos_wdata = v_q;
		case (state_q)
			S_KEY_RD: kr_addr = pos_rdata;
			S_UP_CHK: kr_addr = (v_q - idx_t'(1)) >> 1;
			S_DN_CHK: kr_addr = c_full[IDX_W-1:0];
			S_DN_RD2: kr_addr = c_next[IDX_W-1:0];
			S_UP_CMP: begin
				if (!better) begin
					key_we = 1'b1;
					pos_we = 1'b1;
					key_wdata = key_rdata;
					id_wdata = id_rdata;
					pos_waddr = id_rdata;
				end
			end
			S_DN_CMP: begin
				if (better) begin
					key_we = 1'b0;
				end else begin
					key_we = 1'b1;
					pos_we = 1'b1;
					key_wdata = kc_q;
					id_wdata = idc_q;
					pos_waddr = idc_q;
				end
			end
			S_FIN: begin
				key_we = 1'b1;
				pos_we = 1'b1;
			end
			default: kr_addr = p_q;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			max_mode_q <= 1'b0;
			fill_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_mode_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q <= action;
						elem_q <= element;
						val_q <= value;
						st_q <= ST_OK;
						newel_q <= '0;
						k_q <= '0;
						if (action == ACT_INSERT) begin
							if (fill_q >= cnt_t'(CAPACITY)) begin
								st_q <= ST_FULL;
								state_q <= S_DONE;
							end else begin
								k_q <= value;
								d_q <= fill_q[IDX_W-1:0];
								v_q <= fill_q[IDX_W-1:0];
								newel_q <= fill_q[IDX_W-1:0];
								fill_q <= fill_q + cnt_t'(1);
								state_q <= S_UP_CHK;
							end
						end else if ({1'b0, element} >= fill_q) begin
							st_q <= ST_ABSENT;
							state_q <= S_DONE;
						end else begin
							state_q <= S_POS_RD;
						end
					end
				end
				S_POS_RD: state_q <= S_KEY_RD;
				S_KEY_RD: begin
					v_q <= pos_rdata;
					d_q <= elem_q;
					state_q <= S_KEY_WAIT;
				end
				S_KEY_WAIT: begin
					if (act_q == ACT_QUERY) begin
						k_q <= key_rdata;
						state_q <= S_DONE;
					end else begin
						k_q <= sat_key;
						if ((act_q == ACT_DEC) == max_mode_q) begin
							state_q <= S_DN_CHK;
						end else begin
							state_q <= S_UP_CHK;
						end
					end
				end
				S_UP_CHK: begin
					p_q <= (v_q - idx_t'(1)) >> 1;
					state_q <= (v_q == '0) ? S_FIN : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (better) begin
						state_q <= S_FIN;
					end else begin
						v_q <= p_q;
						state_q <= S_UP_CHK;
					end
				end
				S_DN_CHK: begin
					c_q <= c_full[IDX_W-1:0];
					state_q <= (c_full >= {1'b0, fill_q}) ? S_FIN : S_DN_RD2;
				end
				S_DN_RD2: begin
					kc_q <= key_rdata;
					idc_q <= id_rdata;
					state_q <= (c_next < fill_q) ? S_DN_CMP2 : S_DN_CMP;
				end
				S_DN_CMP2: begin
					// right child wins only when strictly better
					if (better) begin
						kc_q <= key_rdata;
						idc_q <= id_rdata;
						c_q <= c_next[IDX_W-1:0];
					end
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (better) begin
						state_q <= S_FIN;
					end else begin
						v_q <= c_q;
						state_q <= S_DN_CHK;
					end
				end
				S_FIN: state_q <= S_DONE;
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// top-of-heap shadow and output register
	always_ff @(posedge clk) begin
		if (key_we && key_waddr == '0) begin
			top_key_q <= key_wdata;
			top_id_q <= id_wdata;
		end
		if (out_load) begin
			status_q <= st_q;
			new_element_q <= newel_q;
			key_out_q <= (st_q == ST_OK) ? k_q : '0;
			top_key_o_q <= (fill_q == '0) ? '0 : top_key_q;
			top_el_o_q <= (fill_q == '0) ? '0 : top_id_q;
			is_empty_q <= (fill_q == '0);
			entry_count_q <= fill_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign new_element = new_element_q;
	assign key_out = key_out_q;
	assign top_key = top_key_o_q;
	assign top_element = top_el_o_q;
	assign is_empty = is_empty_q;
	assign entry_count = entry_count_q;
endmodule

// ===== verif/tb_indexed_binary_heap.sv =====
// self-checking testbench for the indexed binary heap
`timescale 1ns / 1ps

module tb_indexed_binary_heap;
	import ibh_pkg::*;

	typedef struct {
		logic [1:0] status;
		idx_t new_element;
		key_t key_out;
		key_t top_key;
		idx_t top_element;
		logic is_empty;
		cnt_t entry_count;
	} heap_reply_t;

	class heap_scoreboard;
		longint keys[CAPACITY];
		int ids[CAPACITY];
		int slot_of[CAPACITY];
		int fill;
		bit max_mode;
		heap_reply_t pending[$];
		int errors;

		function bit better(longint a, longint b);
			return max_mode ? (a > b) : (a < b);
		endfunction

		function longint sat_add(longint a, longint b);
			longint hi;
			longint lo;
			hi = 64'sd2147483647;
			lo = -64'sd2147483648;
			if (b > 0 && a > hi - b) return hi;
			if (b < 0 && a < lo - b) return lo;
			return a + b;
		endfunction

		function void swap_slots(int a, int b);
			longint tk;
			int ti;
			tk = keys[a]; ti = ids[a];
			keys[a] = keys[b]; ids[a] = ids[b];
			keys[b] = tk; ids[b] = ti;
			slot_of[ids[a]] = a;
			slot_of[ids[b]] = b;
		endfunction

		function void bubble_up(int id);
			int v;
			int p;
			v = slot_of[id];
			while (v != 0) begin
				p = (v - 1) / 2;
				if (better(keys[p], keys[v])) break;
				swap_slots(p, v);
				v = p;
			end
		endfunction

		function void bubble_down(int id);
			int v;
			int c;
			v = slot_of[id];
			forever begin
				c = 2 * v + 1;
				if (c >= fill) break;
				if (c + 1 < fill && better(keys[c + 1], keys[c])) c = c + 1;
				if (better(keys[v], keys[c])) break;
				swap_slots(v, c);
				v = c;
			end
		endfunction

		function void note_item(logic [1:0] act, idx_t elem, key_t val);
			heap_reply_t r;
			longint amount;
			int v;
			r = '{default: '0};
			amount = longint'(val);
			if (act == ACT_INSERT) begin
				if (fill >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					keys[fill] = amount;
					ids[fill] = fill;
					slot_of[fill] = fill;
					fill++;
					bubble_up(fill - 1);
					r.new_element = idx_t'(fill - 1);
					r.key_out = key_t'(keys[slot_of[fill - 1]]);
				end
			end else if (elem >= fill) begin
				r.status = ST_ABSENT;
			end else begin
				v = slot_of[elem];
				if (act == ACT_DEC) begin
					keys[v] = sat_add(keys[v], -amount);
					if (max_mode) bubble_down(elem); else bubble_up(elem);
				end else if (act == ACT_INC) begin
					keys[v] = sat_add(keys[v], amount);
					if (max_mode) bubble_up(elem); else bubble_down(elem);
				end
				r.key_out = key_t'(keys[slot_of[elem]]);
			end
			r.top_key = fill ? key_t'(keys[0]) : '0;
			r.top_element = fill ? idx_t'(ids[0]) : '0;
			r.is_empty = (fill == 0);
			r.entry_count = cnt_t'(fill);
			pending = {pending, r};
		endfunction

		function void check_reply(heap_reply_t got);
			heap_reply_t e;
			if (pending.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status) begin
				$error("status exp %0d got %0d", e.status, got.status); errors++;
			end
			if (got.new_element !== e.new_element) begin
				$error("new_element exp %0d got %0d", e.new_element, got.new_element);
				errors++;
			end
			if (got.key_out !== e.key_out) begin
				$error("key_out exp %0d got %0d", e.key_out, got.key_out); errors++;
			end
			if (got.top_key !== e.top_key) begin
				$error("top_key exp %0d got %0d", e.top_key, got.top_key); errors++;
			end
			if (got.top_element !== e.top_element) begin
				$error("top_element exp %0d got %0d", e.top_element, got.top_element);
				errors++;
			end
			if (got.is_empty !== e.is_empty) begin
				$error("is_empty exp %0d got %0d", e.is_empty, got.is_empty); errors++;
			end
			if (got.entry_count !== e.entry_count) begin
				$error("entry_count exp %0d got %0d", e.entry_count, got.entry_count);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic [1:0] action;
	idx_t element;
	key_t value;
	logic out_valid;
	logic out_ready;
	logic [1:0] status;
	idx_t new_element;
	key_t key_out;
	key_t top_key;
	idx_t top_element;
	logic is_empty;
	cnt_t entry_count;

	heap_scoreboard board;
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles;

	localparam int WATCHDOG_LIMIT = 20000;

	indexed_binary_heap dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .action(action),
		.element(element), .value(value), .out_valid(out_valid),
		.out_ready(out_ready), .status(status), .new_element(new_element),
		.key_out(key_out), .top_key(top_key), .top_element(top_element),
		.is_empty(is_empty), .entry_count(entry_count)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// receiver side: random stalls, check every accepted result beat
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_reply('{status, new_element, key_out, top_key, top_element,
				is_empty, entry_count});
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// valid stays high after a beat only when the next beat follows at once
	task automatic send_item(logic [1:0] act, idx_t elem, key_t val);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		element <= elem;
		value <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_item(act, elem, val);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		// short settle gap before configuration or the end
		repeat (60) @(posedge clk);
	endtask

	task automatic write_mode(bit m);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.max_mode = m;
	endtask

	function automatic key_t pick_key();
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(64) - 32) <<< 16;
			3: return $signed($urandom_range(20) - 10);
			default: return $urandom;
		endcase
	endfunction

	function automatic idx_t pick_elem();
		if (board.fill > 0 && $urandom_range(9) != 0)
			return idx_t'($urandom_range(board.fill - 1));
		return idx_t'($urandom);
	endfunction

	task automatic random_phase(int n);
		int k;
		logic [1:0] act;
		for (k = 0; k < n; k++) begin
			act = 2'($urandom_range(3));
			// keep inserts frequent early so the heap grows deep
			if (board.fill < 40 && $urandom_range(1)) act = ACT_INSERT;
			send_item(act, pick_elem(), pick_key());
		end
	endtask

	initial begin
		int k;
		board = new();
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		in_valid = 0;
		action = ACT_INSERT;
		element = '0;
		value = '0;
		out_ready = 0;
		quiet_cycles = 0;
		send_idle_pct = 37;
		recv_idle_pct = 62;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty heap, extremes, ties, every action
		send_item(ACT_QUERY, 8'd0, 32'sd0);
		send_item(ACT_DEC, 8'd255, 32'sd5);
		send_item(ACT_INSERT, 8'd0, 32'sh7fffffff);
		send_item(ACT_INSERT, 8'd0, 32'sh80000000);
		send_item(ACT_INSERT, 8'd255, 32'sh00010000);
		send_item(ACT_INSERT, 8'd0, 32'sh00010000);
		send_item(ACT_QUERY, 8'd1, 32'sd0);
		send_item(ACT_DEC, 8'd1, 32'sh7fffffff);
		send_item(ACT_INC, 8'd1, 32'sh7fffffff);
		send_item(ACT_INC, 8'd0, 32'sh80000000);
		send_item(ACT_INC, 8'd2, 32'sd0);
		send_item(ACT_DEC, 8'd3, 32'shffff0000);
		send_item(ACT_QUERY, 8'd4, 32'sd0);
		write_mode(1'b1);
		send_item(ACT_DEC, 8'd2, 32'sh00020000);
		send_item(ACT_INC, 8'd3, 32'sh00030000);
		send_item(ACT_INSERT, 8'd0, 32'sh7fffffff);
		send_item(ACT_QUERY, 8'd255, 32'sd0);

		random_phase(200);
		write_mode(1'b0);
		// fill to capacity to reach the heap-full case
		while (board.fill < CAPACITY) send_item(ACT_INSERT, idx_t'($urandom), pick_key());
		send_item(ACT_INSERT, 8'd0, 32'sd1);
		send_item(ACT_QUERY, 8'd255, 32'sd0);
		send_idle_pct = 62;
		recv_idle_pct = 37;
		random_phase(300);
		write_mode(1'b1);
		random_phase(150);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(200);
		write_mode(1'b0);
		random_phase(100);

		drain();
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
